// ===== sv/duplicate_frame_window_filter_core_macros.svh =====
// Assertion helpers for the duplicate frame window filter.
`ifndef DUPLICATE_FRAME_WINDOW_FILTER_CORE_MACROS_SVH
`define DUPLICATE_FRAME_WINDOW_FILTER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define DFWF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dfwf check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define DFWF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dfwf check failed");

`endif

// ===== sv/dfwf_pkg.sv =====
`default_nettype none
package dfwf_pkg;

  localparam logic [7:0] REPLY_FRAME_TYPE = 8'd2;
  localparam logic [7:0] LENGTH_RESET     = 8'd100;

  localparam int unsigned APB_AW = 3;
  // register index is paddr[2]
  localparam logic REG_WINDOW_LENGTH = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } dfwf_state_e;

  typedef struct packed {
    logic done;
    logic is_repeat;
  } dfwf_result_t;

endpackage
`default_nettype wire

// ===== sv/duplicate_frame_window_filter_core.sv =====
// Channel   Direction  Handshake               Word
// in        input      in_valid_i / in_stall_o frame_count_i, frame_type_i
// out       output     out_valid_o / out_stall_i is_repeat_o, reply_needed_o
// cfg       input      APB psel/penable/pwrite paddr, pwdata, prdata
//
// A new count is compared against the window entries, oldest first, with one window
// memory read and one 32-bit compare per cycle; a repeat ends the scan on its entry,
// and the input stalls until the result is passed on. Reset (rst_ni low, async)
// empties the window and sets window_length to 100; the store itself is not
// cleared. A stalled output holds the block; a result parks in the output
// register, and the next word is taken meanwhile.
`default_nettype none
`include "duplicate_frame_window_filter_core_macros.svh"
module duplicate_frame_window_filter_core #(
  parameter int unsigned WINDOW_DEPTH = 128
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [31:0]                 frame_count_i,
  input  wire logic [7:0]                  frame_type_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             is_repeat_o,
  output logic                             reply_needed_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [dfwf_pkg::APB_AW-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);

  import dfwf_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);
  localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned LW = (CW > 8) ? CW : 8;

  logic [7:0]    len_q, len_d;
  logic          cfg_wr;
  logic [LW-1:0] len_ext;
  logic [LW-1:0] lim_sat;
  logic [CW-1:0] limit;

  logic          in_accept;
  logic          busy;
  logic          out_free;
  logic          load;
  dfwf_result_t  res;

  logic          reply_hold_q;
  logic          out_valid_q, out_valid_d;
  logic          is_repeat_q;
  logic          reply_q;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_WINDOW_LENGTH);
  assign len_d  = cfg_wr ? pwdata[7:0] : len_q;
  assign prdata = (paddr[2] == REG_WINDOW_LENGTH) ? {24'd0, len_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LENGTH_RESET;
    end else begin
      len_q <= len_d;
    end
  end

  // lengths above the store depth saturate
  assign len_ext = LW'(len_q);
  assign lim_sat = (len_ext > LW'(WINDOW_DEPTH)) ? LW'(WINDOW_DEPTH) : len_ext;
  assign limit   = lim_sat[CW-1:0];

  assign in_stall_o = busy;
  assign in_accept  = in_valid_i && !busy;

  assign out_free = !out_valid_q || !out_stall_i;
  assign load     = res.done && out_free;

  dfwf_ctrl #(
    .DEPTH (WINDOW_DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_accept),
    .count_i     (frame_count_i),
    .clear_i     (cfg_wr),
    .limit_i     (limit),
    .out_free_i  (out_free),
    .busy_o      (busy),
    .result_o    (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  dfwf_ram #(
    .DEPTH (WINDOW_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      reply_hold_q <= (frame_type_i == REPLY_FRAME_TYPE);
    end
    if (load) begin
      is_repeat_q <= res.is_repeat;
      reply_q     <= reply_hold_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign is_repeat_o    = is_repeat_q;
  assign reply_needed_o = reply_q;

  // checks
  `DFWF_ASSERT_NEXT(a_accept_goes_busy, in_accept, in_stall_o)
  `DFWF_ASSERT_NOW(a_done_only_busy, res.done, in_stall_o)
  `DFWF_ASSERT_NEXT(a_load_shows_word, load, out_valid_o && !in_stall_o)

endmodule
`default_nettype wire

// ===== sv/dfwf_ram.sv =====
`default_nettype none
module dfwf_ram #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [31:0]   wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [31:0]   rdata_o
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== sv/dfwf_ctrl.sv =====
`default_nettype none
module dfwf_ctrl #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7,
  parameter int unsigned CW    = 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [31:0]            count_i,
  input  wire logic                   clear_i,
  input  wire logic [CW-1:0]          limit_i,
  input  wire logic                   out_free_i,
  output logic                        busy_o,
  output dfwf_pkg::dfwf_result_t      result_o,
  output logic                        ram_we_o,
  output logic      [AW-1:0]          ram_waddr_o,
  output logic      [31:0]            ram_wdata_o,
  output logic                        ram_re_o,
  output logic      [AW-1:0]          ram_raddr_o,
  input  wire logic [31:0]            ram_rdata_i
);

  import dfwf_pkg::*;

  localparam int unsigned SW = CW + 1;

  dfwf_state_e state_q, state_d;

  logic [31:0]   count_q;
  logic [AW-1:0] oldest_q, oldest_d;
  logic [CW-1:0] occ_q, occ_d;
  logic [CW-1:0] issue_q, issue_d;
  logic          pend_q, pend_d;
  logic          repeat_q, repeat_d;

  logic [SW-1:0] sum;
  logic [SW-1:0] wrap;
  logic [AW-1:0] addr;
  logic [AW-1:0] oldest_inc;
  logic          match;
  logic          scan_end;

  // shared ring address unit: oldest + offset, folded once
  assign sum  = SW'(oldest_q) + SW'(issue_q);
  assign wrap = (sum >= SW'(DEPTH)) ? (sum - SW'(DEPTH)) : sum;
  assign addr = wrap[AW-1:0];

  assign oldest_inc = (oldest_q == AW'(DEPTH - 1)) ? '0 : (oldest_q + AW'(1));

  assign match    = pend_q && (ram_rdata_i == count_q);
  assign scan_end = (issue_q == occ_q) && !pend_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (match || scan_end) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy_o             = 1'b1;
    ram_re_o           = 1'b0;
    ram_we_o           = 1'b0;
    result_o.done      = 1'b0;
    result_o.is_repeat = repeat_q;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
      end
      ST_SCAN: begin
        ram_re_o = (issue_q != occ_q);
        // at scan end issue_q == occ_q, so addr is the append slot
        ram_we_o = scan_end && (limit_i != '0);
      end
      ST_DONE: begin
        result_o.done = 1'b1;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

  assign ram_raddr_o = addr;
  assign ram_waddr_o = addr;
  assign ram_wdata_o = count_q;

  // datapath next values
  always_comb begin
    oldest_d = oldest_q;
    occ_d    = occ_q;
    issue_d  = issue_q;
    pend_d   = pend_q;
    repeat_d = repeat_q;
    if (start_i && (state_q == ST_IDLE)) begin
      issue_d  = '0;
      pend_d   = 1'b0;
      repeat_d = 1'b0;
    end else if (state_q == ST_SCAN) begin
      pend_d = ram_re_o;
      if (ram_re_o) issue_d = issue_q + CW'(1);
      if (match) repeat_d = 1'b1;
      if (ram_we_o) begin
        if (occ_q < limit_i) begin
          occ_d = occ_q + CW'(1);
        end else begin
          oldest_d = oldest_inc;
        end
      end
    end
    if (clear_i) begin
      oldest_d = '0;
      occ_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      oldest_q <= '0;
      occ_q    <= '0;
      issue_q  <= '0;
      pend_q   <= 1'b0;
      repeat_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      oldest_q <= oldest_d;
      occ_q    <= occ_d;
      issue_q  <= issue_d;
      pend_q   <= pend_d;
      repeat_q <= repeat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && (state_q == ST_IDLE)) begin
      count_q <= count_i;
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb_duplicate_frame_window_filter_core.sv =====
`default_nettype none
module tb_duplicate_frame_window_filter_core;
  timeunit 1ns;
  timeprecision 1ps;

  import dfwf_pkg::*;

  localparam int unsigned WINDOW_DEPTH = 128;
  localparam int unsigned CYCLE_LIMIT  = 1_500_000;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned PHASE_ITEMS  = 200;
  localparam int unsigned NUM_PHASES   = 10;
  localparam int unsigned MAX_REPORTS  = 10;

  localparam logic [APB_AW-1:0] ADDR_LENGTH = {REG_WINDOW_LENGTH, 2'b00};
  // no register lives here; writes must be dropped
  localparam logic [APB_AW-1:0] ADDR_UNUSED = 3'h4;

  typedef enum logic [1:0] {
    ROW_FRAME,
    ROW_SET_LENGTH,
    ROW_BAD_REG
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [31:0] value;
    logic [7:0]  ftype;
    logic        typed;
    logic        rep;
    logic        rply;
  } dir_row_t;

  typedef struct packed {
    logic rep;
    logic rply;
  } verdict_t;

  localparam int NUM_DIR = 29;
  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    '{ROW_FRAME,      32'h0000_0000, REPLY_FRAME_TYPE, 1'b1, 1'b0, 1'b1},
    '{ROW_FRAME,      32'h0000_0000, 8'h00,            1'b1, 1'b1, 1'b0},
    '{ROW_FRAME,      32'hFFFF_FFFF, 8'hFF,            1'b1, 1'b0, 1'b0},
    '{ROW_FRAME,      32'hFFFF_FFFF, REPLY_FRAME_TYPE, 1'b1, 1'b1, 1'b1},
    '{ROW_FRAME,      32'h0000_0001, 8'h03,            1'b1, 1'b0, 1'b0},
    '{ROW_FRAME,      32'h0000_0000, 8'h01,            1'b1, 1'b1, 1'b0},
    // single-entry window: every new count evicts the previous one
    '{ROW_SET_LENGTH, 32'd1,         8'h00,            1'b0, 1'b0, 1'b0},
    '{ROW_FRAME,      32'd5,         REPLY_FRAME_TYPE, 1'b1, 1'b0, 1'b1},
    '{ROW_FRAME,      32'd5,         8'h80,            1'b1, 1'b1, 1'b0},
    '{ROW_FRAME,      32'd6,         8'h7F,            1'b1, 1'b0, 1'b0},
    '{ROW_FRAME,      32'd5,         8'h00,            1'b1, 1'b0, 1'b0},
    '{ROW_FRAME,      32'd6,         8'h00,            1'b1, 1'b0, 1'b0},
    '{ROW_BAD_REG,    32'd0,         8'h00,            1'b0, 1'b0, 1'b0},
    '{ROW_FRAME,      32'd6,         REPLY_FRAME_TYPE, 1'b1, 1'b1, 1'b1},
    // zero length keeps nothing
    '{ROW_SET_LENGTH, 32'd0,         8'h00,            1'b0, 1'b0, 1'b0},
    '{ROW_FRAME,      32'd7,         8'h00,            1'b1, 1'b0, 1'b0},
    '{ROW_FRAME,      32'd7,         8'h00,            1'b1, 1'b0, 1'b0},
    // full window, repeat must not refresh the entry
    '{ROW_SET_LENGTH, 32'd2,         8'h00,            1'b0, 1'b0, 1'b0},
    '{ROW_FRAME,      32'd8,         8'h40,            1'b0, 1'b0, 1'b0},
    '{ROW_FRAME,      32'd9,         8'h20,            1'b0, 1'b0, 1'b0},
    '{ROW_FRAME,      32'd8,         8'h10,            1'b0, 1'b0, 1'b0},
    '{ROW_FRAME,      32'd10,        8'h08,            1'b0, 1'b0, 1'b0},
    '{ROW_FRAME,      32'd8,         8'h04,            1'b1, 1'b0, 1'b0},
    // above depth saturates
    '{ROW_SET_LENGTH, 32'd255,       8'h00,            1'b0, 1'b0, 1'b0},
    '{ROW_FRAME,      32'h8000_0000, REPLY_FRAME_TYPE, 1'b0, 1'b0, 1'b0},
    '{ROW_FRAME,      32'h7FFF_FFFF, 8'hFE,            1'b0, 1'b0, 1'b0},
    '{ROW_FRAME,      32'h8000_0000, REPLY_FRAME_TYPE, 1'b0, 1'b0, 1'b0},
    '{ROW_SET_LENGTH, 32'd128,       8'h00,            1'b0, 1'b0, 1'b0},
    '{ROW_FRAME,      32'h1234_5678, 8'h55,            1'b0, 1'b0, 1'b0}
  };

  localparam logic [7:0] PHASE_LEN [NUM_PHASES] = '{
    8'd1, 8'd2, 8'd128, 8'd0, 8'd255, 8'd3, 8'd100, 8'd16, 8'd128, 8'd7
  };

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [31:0]       frame_count_i;
  logic [7:0]        frame_type_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic              is_repeat_o;
  logic              reply_needed_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  // model of the block
  logic [31:0] recent_counts[$];
  logic [7:0]  length_reg;
  verdict_t    pending_verdicts[$];

  bit          idle_on;
  bit          hold_req;
  int unsigned mismatches;
  int unsigned frames_sent;
  int unsigned results_seen;
  int unsigned repeats_seen;
  int unsigned replies_seen;
  int unsigned length_writes;
  int unsigned cycle_count;

  duplicate_frame_window_filter_core #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .frame_count_i (frame_count_i),
    .frame_type_i  (frame_type_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .is_repeat_o   (is_repeat_o),
    .reply_needed_o(reply_needed_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #2 clk_i = ~clk_i;

  function automatic int unsigned eff_length(input logic [7:0] len);
    return (len > WINDOW_DEPTH) ? WINDOW_DEPTH : int'(len);
  endfunction

  function automatic verdict_t filter_frame(input logic [31:0] cnt, input logic [7:0] typ);
    verdict_t v;
    v.rep = 1'b0;
    foreach (recent_counts[i]) begin
      if (recent_counts[i] == cnt) v.rep = 1'b1;
    end
    if (!v.rep) begin
      recent_counts.push_back(cnt);
      // zero length drops the count right away
      if (recent_counts.size() > eff_length(length_reg)) void'(recent_counts.pop_front());
    end
    v.rply = (typ == REPLY_FRAME_TYPE);
    return v;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("[%0t] mismatch on %s: expected %0h, got %0h", $realtime, what, exp_v, act_v);
    end
  endtask

  // enters and leaves on a rising edge; in_valid_i stays high for back-to-back words
  task automatic send_frame(input logic [31:0] cnt, input logic [7:0] typ,
                            input logic typed, input logic rep, input logic rply);
    int unsigned gap;
    verdict_t    v;
    gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    frame_count_i <= cnt;
    frame_type_i  <= typ;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    v = filter_frame(cnt, typ);
    if (typed) begin
      v.rep  = rep;
      v.rply = rply;
    end
    pending_verdicts.push_back(v);
    frames_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read(input logic [APB_AW-1:0] addr, output logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_window_length(input logic [7:0] len);
    logic [31:0] rd;
    wait_idle();
    // upper bits are don't-care for an 8-bit register
    apb_write(ADDR_LENGTH, {24'($urandom_range(0, 32'h00FF_FFFF)), len});
    length_reg = len;
    recent_counts.delete();
    length_writes++;
    apb_read(ADDR_LENGTH, rd);
    if (rd[7:0] !== len) note_mismatch("window_length readback", 32'(len), 32'(rd[7:0]));
  endtask

  function automatic logic [31:0] pick_count(input logic [31:0] base, input int unsigned span);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 2) return 32'h0000_0000;
    if (r < 4) return 32'hFFFF_FFFF;
    if (r < 20) return $urandom;
    return base + $urandom_range(0, span);
  endfunction

  function automatic logic [7:0] pick_type();
    if ($urandom_range(0, 99) < 35) return REPLY_FRAME_TYPE;
    return 8'($urandom_range(0, 255));
  endfunction

  // output side: random stall bursts, one long hold on request
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    logic        nxt;
    verdict_t    v;
    stall_left  = 0;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        results_seen++;
        if (is_repeat_o === 1'b1) repeats_seen++;
        if (reply_needed_o === 1'b1) replies_seen++;
        if (pending_verdicts.size() == 0) begin
          note_mismatch("unexpected result word", 32'h0, {30'h0, is_repeat_o, reply_needed_o});
        end else begin
          v = pending_verdicts.pop_front();
          if (is_repeat_o !== v.rep) begin
            note_mismatch("is_repeat", 32'(v.rep), 32'(is_repeat_o));
          end
          if (reply_needed_o !== v.rply) begin
            note_mismatch("reply_needed", 32'(v.rply), 32'(reply_needed_o));
          end
        end
      end
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        nxt = 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 3) - 1;
        nxt = 1'b1;
      end else begin
        nxt = 1'b0;
      end
      out_stall_i <= nxt;
    end
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pending_verdicts.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] rd;
    logic [31:0] base;
    logic [7:0]  len;
    int unsigned span;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    frame_count_i = '0;
    frame_type_i  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    idle_on       = 1'b1;
    hold_req      = 1'b0;
    mismatches    = 0;
    frames_sent   = 0;
    results_seen  = 0;
    repeats_seen  = 0;
    replies_seen  = 0;
    length_writes = 0;
    length_reg    = LENGTH_RESET;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apb_read(ADDR_LENGTH, rd);
    if (rd[7:0] !== LENGTH_RESET) begin
      note_mismatch("window_length after reset", 32'(LENGTH_RESET), 32'(rd[7:0]));
    end

    foreach (DIR_ROWS[r]) begin
      case (DIR_ROWS[r].kind)
        ROW_FRAME: begin
          send_frame(DIR_ROWS[r].value, DIR_ROWS[r].ftype, DIR_ROWS[r].typed,
                     DIR_ROWS[r].rep, DIR_ROWS[r].rply);
        end
        ROW_SET_LENGTH: begin
          set_window_length(DIR_ROWS[r].value[7:0]);
        end
        default: begin
          wait_idle();
          apb_write(ADDR_UNUSED, DIR_ROWS[r].value);
        end
      endcase
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      len = PHASE_LEN[p];
      if (p == 5) len = 8'($urandom_range(1, WINDOW_DEPTH));
      if (p == 7) len = 8'($urandom_range(WINDOW_DEPTH + 1, 255));
      idle_on = !(p == 6 || p >= 8);
      set_window_length(len);
      base = $urandom;
      span = eff_length(len) + eff_length(len) / 2 + 2;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // short window drains fast, so a long output hold backs up the input
        if (p == 1 && k == 50) hold_req = 1'b1;
        send_frame(pick_count(base, span), pick_type(), 1'b0, 1'b0, 1'b0);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (WINDOW_DEPTH + 8) @(posedge clk_i);

    $display("%0d frames sent, %0d checked (%0d repeats, %0d reply requests)",
             frames_sent, results_seen, repeats_seen, replies_seen);
    $display("across %0d length settings, incl. zero, saturating, full-depth and a long hold",
             length_writes);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
